### rtl/nwm_pkg.sv
// Shared types and calendar constant tables for the nth weekday of month pipeline.
package nwm_pkg;

    typedef logic [2:0] mod7_t;

    typedef struct packed {
        logic signed [3:0] ordinal;
        logic [2:0]        weekday;
        logic [3:0]        month;
    } query_t;

    typedef struct packed {
        query_t     query;
        logic       leap;
        logic [5:0] fold;
    } year_info_t;

    localparam logic [3:0]  MONTH_FIRST = 4'd1;
    localparam logic [3:0]  MONTH_LAST  = 4'd12;
    localparam logic [13:0] YEAR_ZERO_ALIAS = 14'd399;

    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [10:0] DIV25_MUL    = 11'd1311;
    localparam int          DIV25_SHIFT  = 15;

    // Day-of-year offset of the first day of each month, modulo 7.
    localparam mod7_t START_OFF_COMMON [16] = '{
        3'd0, 3'd0, 3'd3, 3'd3, 3'd6, 3'd1, 3'd4, 3'd6,
        3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd0, 3'd0, 3'd0
    };
    localparam mod7_t START_OFF_LEAP [16] = '{
        3'd0, 3'd0, 3'd3, 3'd4, 3'd0, 3'd2, 3'd5, 3'd0,
        3'd3, 3'd6, 3'd1, 3'd4, 3'd6, 3'd0, 3'd0, 3'd0
    };

    // Day-of-year offset of the last day of each month, modulo 7.
    localparam mod7_t END_OFF_COMMON [16] = '{
        3'd0, 3'd2, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd1,
        3'd4, 3'd6, 3'd2, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0
    };
    localparam mod7_t END_OFF_LEAP [16] = '{
        3'd0, 3'd2, 3'd3, 3'd6, 3'd1, 3'd4, 3'd6, 3'd2,
        3'd5, 3'd0, 3'd3, 3'd5, 3'd1, 3'd0, 3'd0, 3'd0
    };

    localparam logic [4:0] LEN_COMMON [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };
    localparam logic [4:0] LEN_LEAP [16] = '{
        5'd0, 5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

endpackage

### rtl/nwm_year.sv
// Year stages: century quotients, leap-year test and weekday-of-January-first folding.
module nwm_year (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [3:0]   in_ordinal,
    input  logic [2:0]          in_weekday,
    input  logic [3:0]          in_month,
    input  logic [13:0]         in_year,
    output logic                out_valid,
    input  logic                out_ready,
    output nwm_pkg::year_info_t out_info
);
    import nwm_pkg::*;

    logic        en_a, en_b;
    logic        a_valid_reg, b_valid_reg;
    query_t      a_query_reg, a_query_next;
    logic [13:0] a_y_reg, a_y_next;
    logic [7:0]  a_q100_reg, a_q100_next;
    logic [5:0]  a_q400_reg, a_q400_next;
    logic [26:0] prod100;
    logic [20:0] prod400;
    logic [3:0]  month_clamped;
    year_info_t  b_info_reg, b_info_next;
    logic [13:0] rem100, rem400;
    logic [14:0] sum;

    assign en_b     = !b_valid_reg || out_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    always_comb begin
        if (in_month < MONTH_FIRST) begin
            month_clamped = MONTH_FIRST;
        end else if (in_month > MONTH_LAST) begin
            month_clamped = MONTH_LAST;
        end else begin
            month_clamped = in_month;
        end
        a_y_next    = (in_year == 14'd0) ? YEAR_ZERO_ALIAS : in_year - 14'd1;
        prod100     = 27'(a_y_next) * 27'(DIV100_MUL);
        prod400     = 21'(a_y_next[13:4]) * 21'(DIV25_MUL);
        a_q100_next = prod100[DIV100_SHIFT +: 8];
        a_q400_next = prod400[DIV25_SHIFT +: 6];
        a_query_next.ordinal = in_ordinal;
        a_query_next.weekday = in_weekday;
        a_query_next.month   = month_clamped;
    end

    always_comb begin
        rem100 = a_y_reg - 14'(a_q100_reg) * 14'd100;
        rem400 = a_y_reg - 14'(a_q400_reg) * 14'd400;
        sum    = 15'(a_y_reg) + 15'(a_y_reg[13:2]) - 15'(a_q100_reg)
               + 15'(a_q400_reg) + 15'd1;
        b_info_next.query = a_query_reg;
        b_info_next.leap  = ((a_y_reg[1:0] == 2'b11) && (rem100 != 14'd99))
                          || (rem400 == 14'd399);
        b_info_next.fold  = 6'(sum[2:0]) + 6'(sum[5:3]) + 6'(sum[8:6])
                          + 6'(sum[11:9]) + 6'(sum[14:12]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (en_a) begin
                a_valid_reg <= in_valid;
            end
            if (en_b) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_query_reg <= a_query_next;
            a_y_reg     <= a_y_next;
            a_q100_reg  <= a_q100_next;
            a_q400_reg  <= a_q400_next;
        end
        if (en_b) begin
            b_info_reg <= b_info_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_info  = b_info_reg;

endmodule

### rtl/nwm_day.sv
// Day stages: weekday of the month edge and the final day-of-month arithmetic.
module nwm_day (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  nwm_pkg::year_info_t in_info,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [6:0]   out_day
);
    import nwm_pkg::*;

    logic              en_c, en_d;
    logic              c_valid_reg, d_valid_reg;
    logic signed [3:0] c_ord_reg;
    logic [2:0]        c_wd_reg;
    logic [2:0]        c_edge_reg, c_edge_next;
    logic [4:0]        c_len_reg, c_len_next;
    logic [3:0]        f1, e_sum;
    mod7_t             j1, off, e_mod;
    logic signed [6:0] d_day_reg, d_day_next;
    logic [3:0]        t_pos, t_neg;
    logic [3:0]        r_pos, r_neg;
    logic signed [7:0] ord_ext, step, len_s, day;

    assign en_d     = !d_valid_reg || out_ready;
    assign en_c     = !c_valid_reg || en_d;
    assign in_ready = en_c;

    always_comb begin
        f1 = 4'(in_info.fold[5:3]) + 4'(in_info.fold[2:0]);
        j1 = (f1 >= 4'd7) ? 3'(f1 - 4'd7) : f1[2:0];
        if (in_info.query.ordinal[3]) begin
            off = in_info.leap ? END_OFF_LEAP[in_info.query.month]
                               : END_OFF_COMMON[in_info.query.month];
        end else begin
            off = in_info.leap ? START_OFF_LEAP[in_info.query.month]
                               : START_OFF_COMMON[in_info.query.month];
        end
        c_len_next  = in_info.leap ? LEN_LEAP[in_info.query.month]
                                   : LEN_COMMON[in_info.query.month];
        e_sum       = 4'(off) + 4'(j1);
        e_mod       = (e_sum >= 4'd7) ? 3'(e_sum - 4'd7) : e_sum[2:0];
        c_edge_next = e_mod + 3'd1;
    end

    always_comb begin
        t_pos   = 4'(c_wd_reg) + 4'd7 - 4'(c_edge_reg);
        t_neg   = 4'(c_edge_reg) + 4'd7 - 4'(c_wd_reg);
        r_pos   = (t_pos >= 4'd7) ? t_pos - 4'd7 : t_pos;
        if (t_neg >= 4'd14) begin
            r_neg = t_neg - 4'd14;
        end else if (t_neg >= 4'd7) begin
            r_neg = t_neg - 4'd7;
        end else begin
            r_neg = t_neg;
        end
        ord_ext = $signed({{4{c_ord_reg[3]}}, c_ord_reg});
        step    = ord_ext * 8'sd7;
        len_s   = $signed({3'b000, c_len_reg});
        if (c_ord_reg[3]) begin
            day = len_s + step + 8'sd7 - $signed({4'b0000, r_neg});
        end else begin
            day = 8'sd1 + step - 8'sd7 + $signed({4'b0000, r_pos});
        end
        d_day_next = day[6:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (en_c) begin
                c_valid_reg <= in_valid;
            end
            if (en_d) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c) begin
            c_ord_reg  <= in_info.query.ordinal;
            c_wd_reg   <= in_info.query.weekday;
            c_edge_reg <= c_edge_next;
            c_len_reg  <= c_len_next;
        end
        if (en_d) begin
            d_day_reg <= d_day_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_day   = d_day_reg;

endmodule

### rtl/nth_weekday_of_month.sv
// Top level of the nth weekday of month calculator.
//
// A request carries an ordinal (1..5 from the start of the month, -1..-5
// from its end), a weekday (1 is Sunday), a month and a Gregorian year.
// The result is the day of the month of that occurrence; a value below 1
// or past the month end means the occurrence does not exist.
// Both channels use valid and ready; a request or result moves on a clock
// edge at which both are high.
// The block is a four-stage pipeline: year quotients, leap test and
// weekday folding, month edge weekday, day arithmetic. Each stage ends in
// a register, so the result is registered, and one request can be taken
// every cycle while the receiver keeps m_ready high.
// Each stage holds while the stage after it is full and stalled, so an
// empty stage still takes new work while the result register waits for
// the receiver. When every stage is full and m_ready is low, s_ready is low.
// The synchronous active-low reset empties the pipeline.
module nth_weekday_of_month (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [3:0]  s_ordinal,
    input  logic [2:0]         s_weekday,
    input  logic [3:0]         s_month,
    input  logic [13:0]        s_year,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [6:0]  m_day_of_month
);
    import nwm_pkg::*;

    logic       mid_valid, mid_ready;
    year_info_t mid_info;

    nwm_year u_year (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_ordinal (s_ordinal),
        .in_weekday (s_weekday),
        .in_month   (s_month),
        .in_year    (s_year),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .out_info   (mid_info)
    );

    nwm_day u_day (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_info   (mid_info),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_day   (m_day_of_month)
    );

endmodule

### rtl/nwm_checker.sv
// Port-level checks for the nth weekday of month block and their binding.
module nwm_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic signed [6:0] m_day_of_month
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_day_of_month))
        else $error("Stalled result changed or vanished.");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("Request did not reach the output in four cycles.");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("Input stalled while the output was free.");

endmodule

bind nth_weekday_of_month nwm_checker u_nwm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_day_of_month (m_day_of_month)
);

### bench/tb_nth_weekday_of_month.sv
// Self-checking testbench for nth_weekday_of_month with random flow control on both channels.
`timescale 1ns / 100ps

module tb_nth_weekday_of_month;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_COUNT   = 650;
    localparam int HOLD_CYCLES    = 60;

    typedef struct {
        logic signed [3:0] ordinal;
        logic [2:0]        weekday;
        logic [3:0]        month;
        logic [13:0]       year;
    } request_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic signed [3:0] s_ordinal = '0;
    logic [2:0]        s_weekday = '0;
    logic [3:0]        s_month = '0;
    logic [13:0]       s_year = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic signed [6:0] m_day_of_month;

    request_t          pending_req_q[$];
    logic signed [6:0] expected_day_q[$];
    int                err_cnt = 0;
    int                taken_cnt = 0;
    int                done_cnt = 0;
    int                gap_left = 0;
    int                stall_left = 0;
    int                hold_left = 0;
    int                holds_done = 0;
    int                idle_cnt = 0;
    logic              rx_holding = 1'b0;

    nth_weekday_of_month u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ordinal      (s_ordinal),
        .s_weekday      (s_weekday),
        .s_month        (s_month),
        .s_year         (s_year),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_day_of_month (m_day_of_month)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Zero-based day of the year before the first day of the month.
    function automatic int month_start(int mon, bit leap);
        int v;
        case (mon)
            1:       v = -1;
            2:       v = 30;
            3:       v = 58;
            4:       v = 89;
            5:       v = 119;
            6:       v = 150;
            7:       v = 180;
            8:       v = 211;
            9:       v = 242;
            10:      v = 272;
            11:      v = 303;
            12:      v = 333;
            default: v = 364;
        endcase
        if (leap && mon >= 3) begin
            v++;
        end
        return v;
    endfunction

    function automatic logic signed [6:0] nth_weekday_day(request_t req);
        int ord;
        int wd;
        int mon;
        int yr;
        int y;
        int j1;
        int first;
        int after;
        int len;
        int edge_wd;
        int day;
        bit leap;
        ord = int'(req.ordinal);
        wd = int'(req.weekday);
        mon = int'(req.month);
        yr = int'(req.year);
        if (mon < 1) begin
            mon = 1;
        end
        if (mon > 12) begin
            mon = 12;
        end
        if (yr == 0) begin
            yr = 400;
        end
        leap = ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
        y = yr - 1;
        j1 = (365 * y + y / 4 - y / 100 + y / 400 + 1) % 7;
        first = month_start(mon, leap);
        after = month_start(mon + 1, leap);
        len = after - first;
        if (ord < 0) begin
            edge_wd = (after + j1) % 7 + 1;
            day = len + (ord + 1) * 7 - (edge_wd - wd + 7) % 7;
        end else begin
            edge_wd = (first + 1 + j1) % 7 + 1;
            day = 1 + (ord - 1) * 7 + (wd - edge_wd + 7) % 7;
        end
        return day[6:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_request(int ord, int wd, int mon, int yr);
        request_t req;
        req.ordinal = ord[3:0];
        req.weekday = wd[2:0];
        req.month = mon[3:0];
        req.year = yr[13:0];
        pending_req_q.push_back(req);
    endfunction

    function automatic request_t random_request();
        request_t req;
        int       r;
        int       ord;
        int       yr;
        if ($urandom_range(0, 99) < 85) begin
            ord = $urandom_range(0, 8) - 3;
            if (ord <= 0) begin
                ord = ord - 1;
            end
            req.ordinal = ord[3:0];
            req.weekday = 3'($urandom_range(1, 7));
            req.month = 4'($urandom_range(1, 12));
            r = $urandom_range(0, 99);
            if (r < 55) begin
                yr = $urandom_range(1, 9999);
            end else if (r < 85) begin
                yr = $urandom_range(1, 99) * 100 + $urandom_range(0, 2) - 1;
            end else begin
                yr = $urandom_range(1, 12);
            end
            req.year = yr[13:0];
        end else begin
            req.ordinal = 4'($urandom);
            req.weekday = 3'($urandom);
            req.month = 4'($urandom);
            req.year = 14'($urandom);
        end
        return req;
    endfunction

    always @(posedge aclk) begin : driver
        logic offering;
        request_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            offering = s_valid;
            if (s_valid && s_ready) begin
                offering = 1'b0;
                if (rx_holding || (taken_cnt / 64) % 4 == 1) begin
                    gap_left = 0;
                end else begin
                    gap_left = pick_gap();
                end
                taken_cnt++;
            end
            if (!offering) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_req_q.size() != 0) begin
                    nxt = pending_req_q.pop_front();
                    s_ordinal <= nxt.ordinal;
                    s_weekday <= nxt.weekday;
                    s_month <= nxt.month;
                    s_year <= nxt.year;
                    offering = 1'b1;
                end
            end
            s_valid <= offering;
        end
    end

    always @(posedge aclk) begin : monitor
        logic rdy;
        logic signed [6:0] want;
        request_t seen;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_holding <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_day_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: day_of_month expected none, actual %0d",
                             $time, m_day_of_month);
                end else begin
                    want = expected_day_q.pop_front();
                    if (m_day_of_month !== want) begin
                        err_cnt++;
                        $display("%0t: day_of_month expected %0d, actual %0d",
                                 $time, want, m_day_of_month);
                    end
                end
                done_cnt++;
            end
            if (s_valid && s_ready) begin
                seen.ordinal = s_ordinal;
                seen.weekday = s_weekday;
                seen.month = s_month;
                seen.year = s_year;
                expected_day_q.push_back(nth_weekday_day(seen));
            end
            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (holds_done < 2 && done_cnt >= (holds_done == 0 ? 150 : 450)) begin
                hold_left = HOLD_CYCLES - 1;
                holds_done++;
                rdy = 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if ((done_cnt / 80) % 3 != 1 && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
            m_ready <= rdy;
            rx_holding <= (hold_left != 0);
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cnt = 0;
        end else begin
            idle_cnt++;
        end
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        add_request(1, 1, 1, 1);
        add_request(5, 7, 12, 9999);
        add_request(-1, 1, 2, 2000);
        add_request(-4, 3, 2, 1900);
        add_request(5, 1, 2, 2015);
        add_request(5, 3, 2, 2004);
        add_request(-1, 7, 12, 1);
        add_request(0, 3, 6, 2023);
        add_request(7, 6, 3, 2024);
        add_request(6, 2, 8, 1987);
        add_request(-8, 2, 7, 1999);
        add_request(-2, 4, 11, 100);
        add_request(2, 0, 5, 2022);
        add_request(1, 4, 0, 2021);
        add_request(-1, 5, 13, 2020);
        add_request(3, 2, 15, 1600);
        add_request(1, 1, 1, 0);
        add_request(-2, 7, 2, 0);
        add_request(4, 4, 4, 16383);
        add_request(-3, 6, 10, 12000);
        add_request(5, 5, 9, 400);
        add_request(-4, 2, 3, 4);
        add_request(2, 6, 2, 1800);
        for (int i = 0; i < RANDOM_COUNT; i++) begin
            pending_req_q.push_back(random_request());
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        while (pending_req_q.size() != 0 || s_valid || expected_day_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (err_cnt == 0 && expected_day_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/nwm_pkg.sv
rtl/nwm_year.sv
rtl/nwm_day.sv
rtl/nth_weekday_of_month.sv
rtl/nwm_checker.sv
bench/tb_nth_weekday_of_month.sv
